[src/fsbc_pkg.sv]
package fsbc_pkg;

    localparam int unsigned HALF_W  = 32;
    localparam int unsigned BLOCK_W = 64;

    // Forward AES S-box
    localparam logic [7:0] FWD_SBOX [0:255] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // Inverse AES S-box
    localparam logic [7:0] INV_SBOX [0:255] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    typedef logic [HALF_W-1:0]  t_half;
    typedef logic [BLOCK_W-1:0] t_block;

    // Status of the key schedule unit, seen by the sequencer
    typedef struct packed {
        logic busy;
        logic last;
    } t_ks_stat;

    // Bytewise forward substitution
    function automatic t_half sub_word_fwd(input t_half x);
        return {FWD_SBOX[x[31:24]], FWD_SBOX[x[23:16]], FWD_SBOX[x[15:8]], FWD_SBOX[x[7:0]]};
    endfunction

    // Bytewise inverse substitution
    function automatic t_half sub_word_inv(input t_half x);
        return {INV_SBOX[x[31:24]], INV_SBOX[x[23:16]], INV_SBOX[x[15:8]], INV_SBOX[x[7:0]]};
    endfunction

    // Rotate left, amount modulo 32
    function automatic t_half rotl32(input t_half x, input logic [4:0] amt);
        logic [2*HALF_W-1:0] dbl;
        dbl = {x, x} << amt;
        return dbl[2*HALF_W-1:HALF_W];
    endfunction

endpackage

[src/fsbc_in_if.sv]
interface fsbc_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] block_in;

    modport source (output valid, output operation, output block_in, input ready);
    modport sink   (input valid, input operation, input block_in, output ready);
endinterface

[src/fsbc_out_if.sv]
interface fsbc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_out;

    modport source (output valid, output block_out, input ready);
    modport sink   (input valid, input block_out, output ready);
endinterface

[src/fsbc_cfg_if.sv]
interface fsbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/fsbc_key_sched.sv]
module fsbc_key_sched #(
    parameter int NUM_ROUNDS = 16,
    parameter int KW         = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  fsbc_pkg::t_half      i_key,
    input  logic [KW-1:0]        i_rd_idx,
    output fsbc_pkg::t_half      o_rd_key,
    output fsbc_pkg::t_ks_stat   o_stat
);
    import fsbc_pkg::*;

    localparam logic [KW-1:0] LAST_IDX = KW'(NUM_ROUNDS - 1);

    logic          r_busy;
    logic [KW-1:0] r_idx;
    t_half         r_w;
    t_half         r_store [NUM_ROUNDS];
    t_half         n_w;

    // One schedule step: substitute, then rotate by round number
    assign n_w = rotl32(sub_word_fwd(r_w), 5'(r_idx) + 5'd1);

    // Schedule sequencer; reset expands the all-zero key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_w    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_w    <= i_key;
        end else if (r_busy) begin
            r_w <= n_w;
            if (r_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Round key store
    always_ff @(posedge i_clk) begin
        if (i_rst_n && !i_start && r_busy) begin
            r_store[r_idx] <= n_w;
        end
    end

    assign o_rd_key    = r_store[i_rd_idx];
    assign o_stat.busy = r_busy;
    assign o_stat.last = r_busy && (r_idx == LAST_IDX);

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= LAST_IDX))
        else $error("key schedule index out of range");
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.last && !i_start) |=> !r_busy)
        else $error("key schedule did not finish after last round");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && r_idx == '0))
        else $error("key schedule did not restart");
endmodule

[src/fsbc_round.sv]
module fsbc_round (
    input  logic             i_decrypt,
    input  fsbc_pkg::t_half  i_left,
    input  fsbc_pkg::t_half  i_right,
    input  fsbc_pkg::t_half  i_key,
    output fsbc_pkg::t_half  o_left,
    output fsbc_pkg::t_half  o_right
);
    import fsbc_pkg::*;

    t_half mix_in;
    t_half mix_out;

    // Round function input: right half for encrypt, left half for decrypt
    assign mix_in  = i_decrypt ? i_left : i_right;
    assign mix_out = sub_word_inv(mix_in ^ i_key);

    // Encrypt: (L,R) <- (R, L^F(R)); decrypt: (L,R) <- (R^F(L), L)
    assign o_left  = i_decrypt ? (i_right ^ mix_out) : i_right;
    assign o_right = i_decrypt ? i_left : (i_left ^ mix_out);
endmodule

[src/feistel_sbox_block_cipher_top.sv]
// After input acceptance the rounds run in S_RUN; the result is then valid in S_DONE
// and held until the output takes it. One round per cycle through a single shared
// round unit; a new block is taken only after the previous result has left.
// Reset: synchronous active low; afterwards the key schedule of the zero key
// is built, during which no block or key write is taken.
// A key write rebuilds the schedule the same way.
module feistel_sbox_block_cipher_top #(
    parameter int NUM_ROUNDS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fsbc_in_if.sink    i_in,
    fsbc_cfg_if.sink   i_cfg,
    fsbc_out_if.source o_out
);
    import fsbc_pkg::*;

    localparam int KW = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
    localparam logic [KW-1:0] LAST_IDX = KW'(NUM_ROUNDS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state        r_state;
    logic [KW-1:0] r_cnt;
    logic [KW-1:0] r_kidx;
    logic          r_dec;
    t_half         r_left;
    t_half         r_right;

    t_ks_stat      ks_stat;
    t_half         round_key;
    t_half         nx_left;
    t_half         nx_right;
    logic          in_fire;
    logic          cfg_fire;

    // A pending key write goes first; a block waits until the schedule is rebuilt
    assign i_in.ready  = (r_state == S_IDLE) && !ks_stat.busy && !i_cfg.valid;
    assign i_cfg.ready = (r_state == S_IDLE) && !ks_stat.busy;
    assign in_fire     = i_in.valid && i_in.ready;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;

    fsbc_key_sched #(
        .NUM_ROUNDS (NUM_ROUNDS),
        .KW         (KW)
    ) u_key_sched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cfg_fire),
        .i_key    (i_cfg.data),
        .i_rd_idx (r_kidx),
        .o_rd_key (round_key),
        .o_stat   (ks_stat)
    );

    fsbc_round u_round (
        .i_decrypt (r_dec),
        .i_left    (r_left),
        .i_right   (r_right),
        .i_key     (round_key),
        .o_left    (nx_left),
        .o_right   (nx_right)
    );

    // Round sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_kidx  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_RUN;
                        r_cnt   <= '0;
                        r_kidx  <= i_in.operation ? LAST_IDX : '0;
                    end
                end
                S_RUN: begin
                    if (r_cnt == LAST_IDX) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_kidx <= r_dec ? (r_kidx - 1'b1) : (r_kidx + 1'b1);
                    end
                end
                S_DONE: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Block halves: loaded on accept, updated once per round
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_dec   <= i_in.operation;
            r_left  <= i_in.block_in[63:32];
            r_right <= i_in.block_in[31:0];
        end else if (r_state == S_RUN) begin
            r_left  <= nx_left;
            r_right <= nx_right;
        end
    end

    assign o_out.valid     = (r_state == S_DONE);
    assign o_out.block_out = {r_left, r_right};

    a_accept_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_RUN && r_cnt == '0))
        else $error("accepted item did not start rounds");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ks_stat.busy |-> (!i_in.ready && !i_cfg.ready))
        else $error("ready while key schedule is building");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt == LAST_IDX) |=> o_out.valid)
        else $error("result not presented after last round");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt <= LAST_IDX))
        else $error("round counter out of range");
endmodule

[bench/tb_feistel_sbox_block_cipher_top.sv]
`timescale 1ns / 1ps

module tb_feistel_sbox_block_cipher_top;
    import fsbc_pkg::*;

    localparam int   ROUNDS    = 16;
    localparam int   LONG_HOLD = 300;
    localparam logic OP_ENC    = 1'b0;
    localparam logic OP_DEC    = 1'b1;

    // Forward AES S-box, kept locally so the prediction does not lean on the RTL tables
    localparam logic [7:0] AES_SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // Cipher predictor and queue of expected output blocks
    class cipher_sb;
        logic [7:0] inv_tab [256];
        t_half      round_keys [ROUNDS];
        t_block     pending_blocks [$];
        int         errors;

        function new();
            for (int v = 0; v < 256; v++) begin
                inv_tab[AES_SBOX[v]] = v[7:0];
            end
            errors = 0;
            load_key('0);
        endfunction

        function t_half sub_bytes(t_half x, bit inverse);
            t_half y;
            for (int b = 0; b < 4; b++) begin
                y[8*b +: 8] = inverse ? inv_tab[x[8*b +: 8]] : AES_SBOX[x[8*b +: 8]];
            end
            return y;
        endfunction

        function t_half rot_left(t_half x, int amt);
            int a;
            a = amt % 32;
            if (a == 0) return x;
            return (x << a) | (x >> (32 - a));
        endfunction

        // Round key schedule: substitute, then rotate by round number
        function void load_key(t_half k);
            t_half w;
            w = k;
            for (int r = 1; r <= ROUNDS; r++) begin
                w = rot_left(sub_bytes(w, 1'b0), r);
                round_keys[r-1] = w;
            end
        endfunction

        function t_block transform(logic op, t_block blk);
            t_half lh, rh, keep;
            lh = blk[63:32];
            rh = blk[31:0];
            if (op == OP_ENC) begin
                for (int r = 0; r < ROUNDS; r++) begin
                    keep = rh;
                    rh   = lh ^ sub_bytes(rh ^ round_keys[r], 1'b1);
                    lh   = keep;
                end
            end else begin
                for (int r = ROUNDS - 1; r >= 0; r--) begin
                    keep = lh;
                    lh   = rh ^ sub_bytes(lh ^ round_keys[r], 1'b1);
                    rh   = keep;
                end
            end
            return {lh, rh};
        endfunction

        function void note_block(logic op, t_block blk);
            pending_blocks.push_back(transform(op, blk));
        endfunction

        function void check_block(t_block got);
            t_block want;
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected block %h, none pending", $time, got);
                errors++;
                return;
            end
            want = pending_blocks.pop_front();
            if (want !== got) begin
                $display("%0t: block mismatch, expected %h, got %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;
    int   hold_asks;

    cipher_sb sb = new();

    fsbc_in_if  in_if();
    fsbc_cfg_if cfg_if();
    fsbc_out_if out_if();

    feistel_sbox_block_cipher_top #(.NUM_ROUNDS(ROUNDS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_block(input logic op, input t_block blk);
        int gap;
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.block_in  <= blk;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_block(op, blk);
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_key(input t_half k);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= k;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.load_key(k);
        cfg_if.valid <= 1'b0;
    endtask

    // Stop offering blocks and wait until every expected block is back
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (sb.pending_blocks.size() != 0) @(posedge i_clk);
    endtask

    // Output side: check accepted items, drive ready with stalls and holds
    initial begin
        int stall_left;
        int hold_left;
        int hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) sb.check_block(out_if.block_out);
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (steady || $urandom_range(0, 2) != 0) begin
                out_if.ready <= 1'b1;
            end else begin
                stall_left = idle_len();
                out_if.ready <= (stall_left == 0);
            end
        end
    end

    // Stimulus
    initial begin
        t_block blk;
        logic   op;
        t_half  key;
        int     r;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.operation <= OP_ENC;
        in_if.block_in  <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.data     <= '0;
        steady          <= 1'b0;
        hold_asks       <= 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Schedule left by reset (zero key): extreme and patterned blocks
        send_block(OP_ENC, '0);
        send_block(OP_ENC, '1);
        send_block(OP_DEC, '0);
        send_block(OP_DEC, '1);
        send_block(OP_ENC, 64'hAAAA_AAAA_AAAA_AAAA);
        send_block(OP_DEC, 64'h5555_5555_5555_5555);
        send_block(OP_ENC, 64'h0000_0000_FFFF_FFFF);
        send_block(OP_DEC, 64'hFFFF_FFFF_0000_0000);
        send_block(OP_ENC, 64'h0123_4567_89AB_CDEF);
        send_block(OP_DEC, sb.transform(OP_ENC, 64'h0123_4567_89AB_CDEF));
        wait_drain();

        // All-ones key
        write_key(32'hFFFF_FFFF);
        send_block(OP_ENC, '0);
        send_block(OP_DEC, '0);
        send_block(OP_ENC, '1);
        send_block(OP_DEC, '1);
        wait_drain();

        // Zero key written explicitly
        write_key('0);
        send_block(OP_ENC, 64'h1);
        send_block(OP_DEC, 64'h8000_0000_0000_0000);

        // Random phases, one key each
        for (int ph = 0; ph < 8; ph++) begin
            wait_drain();
            case (ph)
                1:       key = 32'hFFFF_FFFF;
                3:       key = '0;
                5:       key = 32'h8000_0001;
                default: key = $urandom;
            endcase
            write_key(key);
            steady <= (ph == 2);
            for (int i = 0; i < 125; i++) begin
                // long receiver hold while blocks keep coming
                if (ph == 1 && i == 20) hold_asks <= hold_asks + 1;
                // sender pause until the block is empty
                if (ph == 4 && i == 60) wait_drain();
                r   = $urandom_range(0, 9);
                op  = 1'($urandom_range(0, 1));
                blk = {$urandom, $urandom};
                if (r == 0) begin
                    blk = '0;
                end else if (r == 1) begin
                    blk = '1;
                end else if (r == 2) begin
                    // decrypt of a known ciphertext
                    op  = OP_DEC;
                    blk = sb.transform(OP_ENC, {$urandom, $urandom});
                end
                send_block(op, blk);
            end
        end

        wait_drain();
        repeat (3 * ROUNDS) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_blocks.size() == 0) begin
            $display("PASS feistel_sbox_block_cipher_top");
        end else begin
            $display("FAIL feistel_sbox_block_cipher_top");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("FAIL feistel_sbox_block_cipher_top");
        $finish;
    end

endmodule
